[hdl/lph_pkg.sv]
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared widths, status codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lph_pkg;

	localparam int KEY_W     = 31;
	localparam int STATUS_W  = 2;
	localparam int SLOT_W    = 6;
	localparam int CFG_W     = 7;
	localparam int TDATA_IN_W  = 32;
	localparam int TDATA_OUT_W = 8;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_FOUND     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    start;
		logic    load_idx;
		logic    advance;
		logic    write;
		logic    emit;
		status_t res_status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mode;
		logic mod_done;
		logic occ;
		logic match;
		logic last;
	} stat_t;

endpackage

[hdl/lph_mod.sv]
// ----------------------------------------------------------------------------
// Bit-serial remainder unit
// Computes key modulo the table size, one key bit per cycle (restoring form).
// ----------------------------------------------------------------------------
module lph_mod #(
	parameter int IW = 6,
	parameter int SW = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [lph_pkg::KEY_W-1:0] key,
	input  logic [SW-1:0]            size,
	output logic [IW-1:0]            rem,
	output logic                     done
);

	localparam int CW = $clog2(lph_pkg::KEY_W);

	logic [lph_pkg::KEY_W-1:0] key_sh_q;
	logic [IW-1:0]             rem_q;
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [IW:0]               sh;
	logic [IW:0]               size_ext;
	logic [IW:0]               diff;

	assign sh       = {rem_q, key_sh_q[lph_pkg::KEY_W-1]};
	assign size_ext = (IW+1)'(size);
	assign diff     = sh - size_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(lph_pkg::KEY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder stays below the size, so one subtract per bit suffices.
	always_ff @(posedge clk) begin
		if (start) begin
			key_sh_q <= key;
			rem_q    <= '0;
		end else if (busy_q) begin
			key_sh_q <= {key_sh_q[lph_pkg::KEY_W-2:0], 1'b0};
			if (sh >= size_ext)
				rem_q <= diff[IW-1:0];
			else
				rem_q <= sh[IW-1:0];
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

endmodule

[hdl/lph_dp.sv]
// ----------------------------------------------------------------------------
// Linear probe hash table datapath
// Size register, remainder unit, probe pointer, key memory, occupied flags
// and the result register.
// ----------------------------------------------------------------------------
module lph_dp #(
	parameter int DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [lph_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic [lph_pkg::KEY_W-1:0]       in_key,
	input  logic                            in_mode,
	input  lph_pkg::cmd_t                   cmd,
	output lph_pkg::stat_t                  stat,
	output logic [lph_pkg::STATUS_W-1:0]    out_status,
	output logic [lph_pkg::SLOT_W-1:0]      out_index
);

	// The size register tops out at 127, so slots beyond 128 are never reached.
	localparam int SLOTS = (DEPTH < 128) ? DEPTH : 128;
	localparam int IW    = $clog2(SLOTS);
	localparam int SW    = $clog2(SLOTS + 1);
	localparam logic [7:0] SLOTS8 = 8'(SLOTS);

	logic [lph_pkg::CFG_W-1:0]  table_size_q;
	logic [7:0]                 ts_ext;
	logic [7:0]                 eff8;
	logic [SW-1:0]              eff_size;
	logic [SW-1:0]              last_n;
	logic [IW-1:0]              rem;
	logic                       mod_done;
	logic [IW-1:0]              idx_q;
	logic [SW-1:0]              n_q;
	logic [IW:0]                idx_inc;
	logic [lph_pkg::KEY_W-1:0]  key_q;
	logic                       mode_q;
	logic [SLOTS-1:0]           occ_q;
	logic [lph_pkg::KEY_W-1:0]  mem [SLOTS];
	logic [lph_pkg::KEY_W-1:0]  rd_q;
	logic [IW+lph_pkg::SLOT_W-1:0] idx_ext;
	logic [lph_pkg::STATUS_W-1:0]  out_status_q;
	logic [lph_pkg::SLOT_W-1:0]    out_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			table_size_q <= lph_pkg::CFG_RESET;
		else if (cfg_wen)
			table_size_q <= cfg_wdata;
	end

	// A size of zero acts as one; sizes past the slot count saturate.
	assign ts_ext = {1'b0, table_size_q};
	always_comb begin
		if (ts_ext == 8'd0)
			eff8 = 8'd1;
		else if (ts_ext > SLOTS8)
			eff8 = SLOTS8;
		else
			eff8 = ts_ext;
	end
	assign eff_size = eff8[SW-1:0];
	assign last_n   = eff_size - 1'b1;

	lph_mod #(.IW(IW), .SW(SW)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.key    (in_key),
		.size   (eff_size),
		.rem    (rem),
		.done   (mod_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q  <= in_key;
			mode_q <= in_mode;
		end
	end

	assign idx_inc = (IW+1)'(idx_q) + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load_idx) begin
			idx_q <= rem;
			n_q   <= '0;
		end else if (cmd.advance) begin
			idx_q <= (idx_inc >= (IW+1)'(eff_size)) ? '0 : idx_inc[IW-1:0];
			n_q   <= n_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			occ_q <= '0;
		else if (cmd.write)
			occ_q[idx_q] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.write)
			mem[idx_q] <= key_q;
		rd_q <= mem[idx_q];
	end

	assign idx_ext = (IW+lph_pkg::SLOT_W)'(idx_q);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= cmd.res_status;
			if (cmd.res_status == lph_pkg::ST_INSERTED || cmd.res_status == lph_pkg::ST_FOUND)
				out_index_q <= idx_ext[lph_pkg::SLOT_W-1:0];
			else
				out_index_q <= '0;
		end
	end

	assign stat.mode     = mode_q;
	assign stat.mod_done = mod_done;
	assign stat.occ      = occ_q[idx_q];
	assign stat.match    = (rd_q == key_q);
	assign stat.last     = (n_q == last_n);

	assign out_status = out_status_q;
	assign out_index  = out_index_q;

endmodule

[hdl/lph_ctrl.sv]
// ----------------------------------------------------------------------------
// Linear probe hash table controller
// Sequences remainder, probe and compare steps and owns both handshakes.
// ----------------------------------------------------------------------------
module lph_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  lph_pkg::stat_t stat,
	output lph_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		IDLE,
		MOD,
		PROBE,
		COMPARE,
		DONE
	} state_t;

	state_t           state_q;
	lph_pkg::status_t res_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd            = '0;
		cmd.res_status = res_q;
		unique case (state_q)
			IDLE:    cmd.start    = in_valid;
			MOD:     cmd.load_idx = stat.mod_done;
			PROBE: begin
				if (!stat.mode) begin
					cmd.write   = !stat.occ;
					cmd.advance = stat.occ && !stat.last;
				end
			end
			COMPARE: cmd.advance = !stat.match && !stat.last;
			DONE:    cmd.emit    = out_free;
			default: cmd         = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			res_q       <= lph_pkg::ST_INSERTED;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (in_valid)
						state_q <= MOD;
				end
				MOD: begin
					if (stat.mod_done)
						state_q <= PROBE;
				end
				PROBE: begin
					if (!stat.mode) begin
						if (!stat.occ) begin
							res_q   <= lph_pkg::ST_INSERTED;
							state_q <= DONE;
						end else if (stat.last) begin
							res_q   <= lph_pkg::ST_FULL;
							state_q <= DONE;
						end
					end else if (!stat.occ) begin
						res_q   <= lph_pkg::ST_NOT_FOUND;
						state_q <= DONE;
					end else begin
						// Key read for this slot lands in the next cycle.
						state_q <= COMPARE;
					end
				end
				COMPARE: begin
					if (stat.match) begin
						res_q   <= lph_pkg::ST_FOUND;
						state_q <= DONE;
					end else if (stat.last) begin
						res_q   <= lph_pkg::ST_NOT_FOUND;
						state_q <= DONE;
					end else begin
						state_q <= PROBE;
					end
				end
				DONE: begin
					if (out_free)
						state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;

endmodule

[hdl/linear_probe_hash_table.sv]
// Sequence: the bit-serial key remainder, then the probe steps (a key memory
// read, then a compare, for each probe of a search), then the output register.
// One request at a time; the next is taken the cycle after the result is staged.
// Reset: occupied flags clear at once (no clearing pass), table_size returns to 64.
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressed table with insert and search requests over stream ports.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
	parameter int DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [lph_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lph_pkg::TDATA_IN_W-1:0]   s_tdata,   // [30:0] key, [31] zero
	input  logic                             s_tuser,   // [0] mode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lph_pkg::TDATA_OUT_W-1:0]  m_tdata    // [1:0] status, [7:2] slot_index
);

	lph_pkg::cmd_t                  cmd;
	lph_pkg::stat_t                 stat;
	logic [lph_pkg::STATUS_W-1:0]   status;
	logic [lph_pkg::SLOT_W-1:0]     slot_index;

	lph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lph_dp #(.DEPTH(DEPTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_key     (s_tdata[lph_pkg::KEY_W-1:0]),
		.in_mode    (s_tuser),
		.cmd        (cmd),
		.stat       (stat),
		.out_status (status),
		.out_index  (slot_index)
	);

	assign m_tdata = {slot_index, status};

endmodule

[hdl/lph_chk.sv]
// ----------------------------------------------------------------------------
// Linear probe hash table port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module lph_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [lph_pkg::TDATA_IN_W-1:0]   s_tdata,
	input logic                             s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [lph_pkg::TDATA_OUT_W-1:0]  m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The remainder computation alone keeps the block busy after a request.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##20 !s_tready)
		else $error("request accepted during remainder computation");

	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == lph_pkg::ST_FULL || m_tdata[1:0] == lph_pkg::ST_NOT_FOUND)
		|-> m_tdata[7:2] == '0)
		else $error("nonzero slot index on a miss");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a request in flight");

endmodule

bind linear_probe_hash_table lph_chk u_lph_chk (.*);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Linear probe hash table testbench
// Drives insert and search requests over the stream ports under a range of
// table sizes, predicts every reply with a shadow copy of the slot table and
// compares each reply field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int KEY_W  = lph_pkg::KEY_W;
	localparam int SLOT_W = lph_pkg::SLOT_W;
	localparam int CFG_W  = lph_pkg::CFG_W;
	localparam int TABLE_DEPTH = 64;
	localparam bit MODE_INSERT = 1'b0;
	localparam bit MODE_SEARCH = 1'b1;
	localparam logic [KEY_W-1:0] KEY_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		lph_pkg::status_t  status;
		logic [SLOT_W-1:0] slot;
	} reply_t;

	// Shadow of the slot table plus the queue of replies still owed by the block.
	class probe_table_tracker;
		logic [KEY_W-1:0] slot_key [TABLE_DEPTH];
		bit               slot_used [TABLE_DEPTH];
		logic [CFG_W-1:0] size_reg;
		reply_t           expected_replies [$];
		int unsigned      mismatches;

		function new();
			size_reg = lph_pkg::CFG_RESET;
			mismatches = 0;
			foreach (slot_used[i]) begin
				slot_used[i] = 1'b0;
				slot_key[i] = '0;
			end
		endfunction

		function void set_size(logic [CFG_W-1:0] value);
			size_reg = value;
		endfunction

		// Out-of-range sizes saturate to 1..TABLE_DEPTH.
		function int unsigned lap_size();
			if (size_reg == 0)
				return 1;
			if (size_reg > TABLE_DEPTH)
				return TABLE_DEPTH;
			return size_reg;
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		function void note_request(bit mode, logic [KEY_W-1:0] key);
			int unsigned n_slots;
			int unsigned pos;
			int unsigned step;
			reply_t      r;
			n_slots = lap_size();
			pos = key % n_slots;
			r.slot = '0;
			if (mode == MODE_INSERT) begin
				r.status = lph_pkg::ST_FULL;
				for (step = 0; step < n_slots; step++) begin
					if (!slot_used[pos]) begin
						slot_key[pos] = key;
						slot_used[pos] = 1'b1;
						r.status = lph_pkg::ST_INSERTED;
						r.slot = pos[SLOT_W-1:0];
						break;
					end
					pos = (pos + 1 == n_slots) ? 0 : pos + 1;
				end
			end else begin
				r.status = lph_pkg::ST_NOT_FOUND;
				for (step = 0; step < n_slots; step++) begin
					if (!slot_used[pos])
						break;
					if (slot_key[pos] == key) begin
						r.status = lph_pkg::ST_FOUND;
						r.slot = pos[SLOT_W-1:0];
						break;
					end
					pos = (pos + 1 == n_slots) ? 0 : pos + 1;
				end
			end
			expected_replies.push_back(r);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_reply(lph_pkg::status_t got_status, logic [SLOT_W-1:0] got_slot);
			reply_t want;
			if (expected_replies.size() == 0) begin
				report($sformatf("unexpected reply status %0d slot %0d", got_status, got_slot));
			end else begin
				want = expected_replies.pop_front();
				if (got_status !== want.status)
					report($sformatf("status %0d, expected %0d", got_status, want.status));
				if (got_slot !== want.slot)
					report($sformatf("slot %0d, expected %0d", got_slot, want.slot));
			end
		endtask
	endclass

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            cfg_wen = 1'b0;
	logic [CFG_W-1:0]                cfg_wdata = '0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [lph_pkg::TDATA_IN_W-1:0]  s_tdata = '0;   // [30:0] key, [31] zero
	logic                            s_tuser = 1'b0; // [0] mode
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [lph_pkg::TDATA_OUT_W-1:0] m_tdata;        // [1:0] status, [7:2] slot_index

	bit                 idle_allowed = 1'b1;
	logic [KEY_W-1:0]   inserted_keys [$];
	probe_table_tracker tracker = new();

	linear_probe_hash_table #(.DEPTH(TABLE_DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("FAILURE");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= idle_allowed ? ($urandom_range(99) >= 15) : 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_reply(lph_pkg::status_t'(m_tdata[1:0]), m_tdata[7:2]);
	end

	// Leaves tvalid high on return so back-to-back requests need no gap.
	task automatic push_request(input bit mode, input logic [KEY_W-1:0] key);
		@(negedge clk);
		while (idle_allowed && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, key};
		s_tuser <= mode;
		do
			@(posedge clk);
		while (!s_tready);
		tracker.note_request(mode, key);
		if (mode == MODE_INSERT)
			inserted_keys.push_back(key);
	endtask

	task automatic drain_replies();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_size(input logic [CFG_W-1:0] value);
		drain_replies();
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		tracker.set_size(value);
	endtask

	// Mixes fresh wide keys, small keys, keys near the top and keys seen before,
	// so searches hit stored keys and inserts create duplicates.
	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned sel;
		sel = $urandom_range(9);
		if (inserted_keys.size() == 0 && sel > 6)
			sel = 0;
		case (sel) inside
			[0:3]: return KEY_W'($urandom() & KEY_MAX);
			[4:5]: return KEY_W'($urandom_range(255));
			6: return KEY_MAX - KEY_W'($urandom_range(63));
			default: return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
		endcase
	endfunction

	task automatic run_phase(input logic [CFG_W-1:0] size, input int count,
			input int insert_pct);
		write_size(size);
		repeat (count) begin
			push_request(($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_SEARCH,
				pick_key());
		end
	endtask

	initial begin : stimulus
		int waited;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// A size of zero behaves as a single slot.
		write_size(7'd0);
		push_request(MODE_INSERT, KEY_MAX);
		push_request(MODE_INSERT, 31'd5);
		push_request(MODE_SEARCH, KEY_MAX);
		push_request(MODE_SEARCH, 31'd5);
		// Collisions on the home slot push keys forward; a search over a full lap reports not found.
		write_size(7'd3);
		push_request(MODE_INSERT, 31'd0);
		push_request(MODE_INSERT, 31'd3);
		push_request(MODE_INSERT, 31'd6);
		push_request(MODE_SEARCH, 31'd3);
		push_request(MODE_SEARCH, 31'd9);
		// Oversized setting saturates to the full depth.
		write_size(7'd127);
		push_request(MODE_INSERT, 31'd0);
		push_request(MODE_SEARCH, 31'd0);
		push_request(MODE_SEARCH, 31'd64);
		push_request(MODE_INSERT, 31'd63);
		push_request(MODE_INSERT, 31'd127);
		push_request(MODE_SEARCH, 31'd127);
		push_request(MODE_SEARCH, 31'h5555_5555);
		push_request(MODE_SEARCH, 31'h2AAA_AAAA);
		// Shrinking hides the key in the top slot; growing back reveals it.
		write_size(7'd2);
		push_request(MODE_SEARCH, 31'd63);
		push_request(MODE_INSERT, 31'd1);
		write_size(7'd64);
		push_request(MODE_SEARCH, 31'd63);
		push_request(MODE_SEARCH, 31'd1);

		run_phase(7'd5, 145, 40);
		run_phase(7'd12, 145, 40);
		run_phase(7'd20, 145, 35);
		run_phase(7'd33, 145, 35);
		run_phase(7'd48, 145, 30);
		idle_allowed = 1'b0;
		run_phase(7'd64, 145, 30);
		idle_allowed = 1'b1;
		run_phase(7'd40, 145, 20);
		run_phase(7'd17, 145, 20);
		run_phase(7'd1, 140, 20);
		run_phase(7'd0, 140, 20);
		run_phase(7'd127, 145, 20);
		run_phase(7'd64, 145, 20);

		@(negedge clk);
		s_tvalid <= 1'b0;
		waited = 0;
		while (tracker.pending() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);
		if (tracker.pending() != 0)
			tracker.report($sformatf("%0d replies never arrived", tracker.pending()));
		if (tracker.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
hdl/lph_pkg.sv
hdl/lph_mod.sv
hdl/lph_dp.sv
hdl/lph_ctrl.sv
hdl/linear_probe_hash_table.sv
hdl/lph_chk.sv
test/testbench.sv
